// ===== hdl/pidc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pidc_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned OPER_W        = DATA_W + 1;
    localparam int unsigned PROD_W        = 2 * OPER_W;
    localparam int unsigned MAG_W         = 64;
    localparam int unsigned TERM_W        = MAG_W - 16;
    localparam int unsigned ACC_W         = TERM_W + 2;
    localparam int unsigned INT_W         = 18;
    localparam int unsigned ISUM_W        = INT_W + 2;
    localparam int unsigned INT_QUOT_BITS = 18;
    localparam int unsigned DER_QUOT_BITS = 32;
    localparam int unsigned CNT_W         = 5;
    localparam int unsigned STATUS_W      = 2;
    localparam int unsigned CFG_IDX_W     = 2;

    localparam logic [DATA_W-1:0] US_PER_SECOND = 32'd1000000;

    // One million is 64 times 15625. Below the overflow bound the magnitude divided by 64
    // fits 32 bits, and multiplying it by the rounded-up value of 2^45 / 15625 and keeping
    // the bits from 45 upwards gives the exact quotient over that whole range.
    localparam int unsigned       RECIP_PRE_SHIFT = 6;
    localparam int unsigned       RECIP_SHIFT     = 45;
    localparam logic [DATA_W-1:0] US_RECIP        = 32'd2251799814;

    localparam logic signed [ISUM_W-1:0] INT_LIMIT_POS = 20'sd65536;
    localparam logic signed [ISUM_W-1:0] INT_LIMIT_NEG = -20'sd65536;

    localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

    localparam logic [STATUS_W-1:0] STATUS_NORMAL   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PRIMED   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DT_ERROR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] error_sample;
        logic [DATA_W-1:0]        time_us;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive_value;
        logic [STATUS_W-1:0]      status;
    } out_t;

    typedef enum logic [2:0] {
        MUL_NONE   = 3'd0,
        MUL_ERR_DT = 3'd1,
        MUL_DIFF   = 3'd2,
        MUL_KP     = 3'd3,
        MUL_KI     = 3'd4,
        MUL_KD     = 3'd5,
        MUL_RECIP  = 3'd6
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } acc_op_t;

    typedef struct packed {
        logic                capture;
        mul_sel_t            mul;
        logic                prep;
        logic                sel_deriv;
        logic                check;
        logic                div_step;
        logic                int_update;
        logic                sat_deriv;
        acc_op_t             acc;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
    } dp_cmd_t;

    typedef struct packed {
        logic primed;
        logic dt_zero;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/pid_controller_integral_clamp_core.sv =====
// Single-channel PID controller in signed Q16.16 with the integral held within plus or minus
// one. Each input transaction carries an error sample and a wrapping microsecond timestamp and
// yields exactly one result transaction. The first sample after reset only primes the stored
// error and time and answers 0 with status 1; a sample whose timestamp equals the previous one
// answers 0 with status 2 and leaves all state alone. Most of a normal step is spent in the 32
// iterations of the bit-serial divider for the derivative; the integral increment divides by
// one million through a reciprocal multiplication, and one shared 33 by 33 multiplier forms
// all six products. Only one sample is processed at a time; a finished result sits in the
// output register so the next sample can be accepted while it waits. Gains are written through
// the configuration channel at indices 0 (proportional), 1 (integral) and 2 (derivative) and
// must only be changed while the block is idle; other indices are ignored.
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_integral_clamp_core
    import pidc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_t                  in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_t                      out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    pidc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pidc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== hdl/pidc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pidc_ctrl
    import pidc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'h0001,
        S_EVAL   = 13'h0002,
        S_PREP_I = 13'h0004,
        S_CHK_I  = 13'h0008,
        S_UPD_I  = 13'h0010,
        S_PREP_D = 13'h0020,
        S_CHK_D  = 13'h0040,
        S_DIV_D  = 13'h0080,
        S_SAT_D  = 13'h0100,
        S_MUL_KI = 13'h0200,
        S_MUL_KD = 13'h0400,
        S_ACC    = 13'h0800,
        S_DONE   = 13'h1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            res_status_reg <= STATUS_NORMAL;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            res_status_reg <= res_status_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        cmd             = '0;
        in_ready        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                // The first product is started here; it is simply unused on the short paths.
                cmd.mul = MUL_ERR_DT;
                if (!sts.primed) begin
                    res_status_next = STATUS_PRIMED;
                    state_next      = S_DONE;
                end else if (sts.dt_zero) begin
                    res_status_next = STATUS_DT_ERROR;
                    state_next      = S_DONE;
                end else begin
                    state_next = S_PREP_I;
                end
            end
            S_PREP_I:
            begin
                cmd.prep   = 1'b1;
                state_next = S_CHK_I;
            end
            S_CHK_I:
            begin
                // The overflow check and the reciprocal product run in the same cycle.
                cmd.check  = 1'b1;
                cmd.mul    = MUL_RECIP;
                state_next = S_UPD_I;
            end
            S_UPD_I:
            begin
                cmd.int_update = 1'b1;
                cmd.mul        = MUL_DIFF;
                state_next     = S_PREP_D;
            end
            S_PREP_D:
            begin
                cmd.prep      = 1'b1;
                cmd.sel_deriv = 1'b1;
                state_next    = S_CHK_D;
            end
            S_CHK_D:
            begin
                cmd.check  = 1'b1;
                cnt_next   = CNT_W'(DER_QUOT_BITS - 1);
                state_next = S_DIV_D;
            end
            S_DIV_D:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_SAT_D;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_SAT_D:
            begin
                cmd.sat_deriv = 1'b1;
                cmd.mul       = MUL_KP;
                state_next    = S_MUL_KI;
            end
            S_MUL_KI:
            begin
                cmd.mul    = MUL_KI;
                cmd.acc    = ACC_LOAD;
                state_next = S_MUL_KD;
            end
            S_MUL_KD:
            begin
                cmd.mul    = MUL_KD;
                cmd.acc    = ACC_ADD;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc         = ACC_ADD;
                res_status_next = STATUS_NORMAL;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = res_status_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/pidc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pidc_dp
    import pidc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire in_t                  in_data,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data,
    input  wire dp_cmd_t              cmd,
    output dp_sts_t                   sts,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_t                      out_data
);

    // Configuration and controller state
    logic signed [DATA_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic                     primed_reg;
    logic signed [DATA_W-1:0] last_error_reg;
    logic [DATA_W-1:0]        last_time_reg;
    logic signed [INT_W-1:0]  integral_reg;
    logic                     out_valid_reg;
    out_t                     out_data_reg;

    // Working registers for one sample
    logic signed [DATA_W-1:0] err_reg;
    logic [DATA_W-1:0]        now_reg;
    logic [DATA_W-1:0]        dt_reg;
    logic signed [OPER_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic [MAG_W-1:0]         div_reg, div_next;
    logic [DATA_W-1:0]        quot_reg;
    logic                     neg_reg;
    logic                     ovf_reg;
    logic signed [INT_W-1:0]  isum_reg;
    logic signed [DATA_W-1:0] deriv_reg, deriv_next;
    logic signed [ACC_W-1:0]  acc_reg;

    logic signed [OPER_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_prod;
    logic [DATA_W-1:0]        den;
    logic [MAG_W-1:0]         den_ext;
    logic [MAG_W:0]           rem_diff;
    logic                     rem_ge;
    logic [INT_W:0]           step_mag;
    logic signed [ISUM_W-1:0] step_val;
    logic signed [ISUM_W-1:0] isum_wide;
    logic signed [ISUM_W-1:0] isum_clamped;
    logic signed [TERM_W-1:0] term;
    logic signed [ACC_W-1:0]  term_ext;
    logic [DATA_W-1:0]        drive_sat;
    logic                     acc_fits;
    logic                     out_free;

    assign out_free     = !out_valid_reg || out_ready;
    assign sts.primed   = primed_reg;
    assign sts.dt_zero  = (dt_reg == '0);
    assign sts.out_free = out_free;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;

    // Shared multiplier; every operand fits 33 signed bits.
    always_comb begin
        unique case (cmd.mul)
            MUL_ERR_DT:
            begin
                mul_a = {err_reg[DATA_W-1], err_reg};
                mul_b = {1'b0, dt_reg};
            end
            MUL_RECIP:
            begin
                mul_a = {1'b0, mag_reg[RECIP_PRE_SHIFT +: DATA_W]};
                mul_b = {1'b0, US_RECIP};
            end
            MUL_DIFF:
            begin
                mul_a = diff_reg;
                mul_b = {1'b0, US_PER_SECOND};
            end
            MUL_KP:
            begin
                mul_a = {gain_p_reg[DATA_W-1], gain_p_reg};
                mul_b = {err_reg[DATA_W-1], err_reg};
            end
            MUL_KI:
            begin
                mul_a = {gain_i_reg[DATA_W-1], gain_i_reg};
                mul_b = {{(OPER_W - INT_W){isum_reg[INT_W-1]}}, isum_reg};
            end
            MUL_KD:
            begin
                mul_a = {gain_d_reg[DATA_W-1], gain_d_reg};
                mul_b = {deriv_reg[DATA_W-1], deriv_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // Magnitude of the product plus half the divisor gives round-half-away after truncation.
    assign den     = cmd.sel_deriv ? dt_reg : US_PER_SECOND;
    assign den_ext = {{(MAG_W - DATA_W){1'b0}}, den};
    assign mag_next = (prod_reg[MAG_W-1:0] ^ {MAG_W{prod_reg[PROD_W-1]}})
                    + {{(MAG_W - 1){1'b0}}, prod_reg[PROD_W-1]}
                    + {{(MAG_W - DATA_W + 1){1'b0}}, den[DATA_W-1:1]};
    assign div_next = cmd.sel_deriv ? (den_ext << (DER_QUOT_BITS - 1))
                                    : (den_ext << (INT_QUOT_BITS - 1));

    assign rem_diff = {1'b0, mag_reg} - {1'b0, div_reg};
    assign rem_ge   = !rem_diff[MAG_W];

    // Integral step; an overflowing quotient is big enough to force the clamp. Otherwise the
    // quotient by one million sits in the reciprocal product.
    assign step_mag = ovf_reg ? {1'b1, {INT_W{1'b0}}} : {1'b0, prod_reg[RECIP_SHIFT +: INT_W]};
    assign step_val = neg_reg ? (~{1'b0, step_mag} + ISUM_W'(1)) : {1'b0, step_mag};
    assign isum_wide = {{(ISUM_W - INT_W){integral_reg[INT_W-1]}}, integral_reg} + step_val;

    always_comb begin
        priority if (isum_wide > INT_LIMIT_POS) begin
            isum_clamped = INT_LIMIT_POS;
        end else if (isum_wide < INT_LIMIT_NEG) begin
            isum_clamped = INT_LIMIT_NEG;
        end else begin
            isum_clamped = isum_wide;
        end
    end

    always_comb begin
        if (ovf_reg || quot_reg[DATA_W-1]) begin
            deriv_next = neg_reg ? S32_MIN : S32_MAX;
        end else begin
            deriv_next = neg_reg ? (~quot_reg + DATA_W'(1)) : quot_reg;
        end
    end

    // Arithmetic shift of a Q32.32 product by 16 is the floor division.
    assign term     = prod_reg[MAG_W-1:16];
    assign term_ext = {{(ACC_W - TERM_W){term[TERM_W-1]}}, term};

    assign acc_fits  = (&acc_reg[ACC_W-1:DATA_W-1]) || !(|acc_reg[ACC_W-1:DATA_W-1]);
    assign drive_sat = acc_fits ? acc_reg[DATA_W-1:0]
                                : (acc_reg[ACC_W-1] ? S32_MIN : S32_MAX);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            primed_reg     <= 1'b0;
            last_error_reg <= '0;
            last_time_reg  <= '0;
            integral_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_GAIN_P: gain_p_reg <= cfg_data;
                    REG_GAIN_I: gain_i_reg <= cfg_data;
                    REG_GAIN_D: gain_d_reg <= cfg_data;
                    default:    ;
                endcase
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
                unique case (cmd.out_status)
                    STATUS_PRIMED:
                    begin
                        primed_reg     <= 1'b1;
                        last_error_reg <= err_reg;
                        last_time_reg  <= now_reg;
                    end
                    STATUS_NORMAL:
                    begin
                        last_error_reg <= err_reg;
                        last_time_reg  <= now_reg;
                        integral_reg   <= isum_reg;
                    end
                    default:        ;
                endcase
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            err_reg  <= in_data.error_sample;
            now_reg  <= in_data.time_us;
            dt_reg   <= in_data.time_us - last_time_reg;
            diff_reg <= {in_data.error_sample[DATA_W-1], in_data.error_sample}
                      - {last_error_reg[DATA_W-1], last_error_reg};
        end
        if (cmd.mul != MUL_NONE) begin
            prod_reg <= mul_prod;
        end
        if (cmd.prep) begin
            mag_reg  <= mag_next;
            neg_reg  <= prod_reg[PROD_W-1];
            div_reg  <= div_next;
            quot_reg <= '0;
        end
        if (cmd.check) begin
            ovf_reg <= ({1'b0, mag_reg} >= {div_reg, 1'b0});
        end
        if (cmd.div_step) begin
            if (rem_ge) begin
                mag_reg <= rem_diff[MAG_W-1:0];
            end
            quot_reg <= {quot_reg[DATA_W-2:0], rem_ge};
            div_reg  <= div_reg >> 1;
        end
        if (cmd.int_update) begin
            isum_reg <= isum_clamped[INT_W-1:0];
        end
        if (cmd.sat_deriv) begin
            deriv_reg <= deriv_next;
        end
        unique case (cmd.acc)
            ACC_LOAD: acc_reg <= term_ext;
            ACC_ADD:  acc_reg <= acc_reg + term_ext;
            default:  ;
        endcase
        if (cmd.out_load) begin
            out_data_reg.status      <= cmd.out_status;
            out_data_reg.drive_value <= (cmd.out_status == STATUS_NORMAL) ? drive_sat : '0;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pidc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pidc_checker
    import pidc_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire out_t out_data
);

    // A waiting result holds until its transaction completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // Primed and error results always carry a zero drive value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != STATUS_NORMAL |-> out_data.drive_value == '0)
        else $error("non-zero drive on a primed or error result");

    // Only one sample is in flight, so input is refused right after a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a sample is in progress");

    // A fresh result is only produced while the block is busy finishing a sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a sample in progress");

endmodule

bind pid_controller_integral_clamp_core pidc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
